@@ rtl/core/mer_pkg.sv @@
// Shared types, constants and microcode table of the midpoint ellipse rasterizer.
`default_nettype none

package mer_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int AXIS_BITS_DEF  = 9;

    localparam int PC_W = 5;

    // request kind
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_SA,
        OP_SB,
        OP_A,
        OP_B,
        OP_TX,
        OP_YM,
        OP_P,
        OP_X,
        OP_Y,
        OP_X2P3,
        OP_Y2M3,
        OP_ONE
    } t_opnd;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc;

    typedef enum logic [1:0] {
        WB_NONE,
        WB_SA,
        WB_SB
    } t_wb;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_DNEG,
        CND_R2,
        CND_LT
    } t_cnd;

    typedef struct packed {
        t_opnd           opa;
        t_opnd           opb;
        logic            mul_en;
        t_acc            acc;
        logic [1:0]      sh;
        t_wb             wb;
        logic            x_inc;
        logic            y_dec;
        logic            set_r2;
        logic            q_load;
        logic            fin;
        t_cnd            cnd;
        logic [PC_W-1:0] target;
        logic            last;
    } t_uword;

    typedef struct packed {
        logic d_neg;
        logic r2;
        logic lt;
        logic active;
        logic done;
    } t_dstat;

    localparam t_uword UW_NOP = '{
        opa:    OP_ONE,
        opb:    OP_ONE,
        mul_en: 1'b0,
        acc:    ACC_NONE,
        sh:     2'd0,
        wb:     WB_NONE,
        x_inc:  1'b0,
        y_dec:  1'b0,
        set_r2: 1'b0,
        q_load: 1'b0,
        fin:    1'b0,
        cnd:    CND_NEVER,
        target: '0,
        last:   1'b0
    };

    // program entry points and steps
    localparam logic [PC_W-1:0] PC_ST0  = PC_W'(0);
    localparam logic [PC_W-1:0] PC_ST1  = PC_W'(1);
    localparam logic [PC_W-1:0] PC_ST2  = PC_W'(2);
    localparam logic [PC_W-1:0] PC_ST3  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_ST4  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_ST5  = PC_W'(5);
    localparam logic [PC_W-1:0] PC_AD0  = PC_W'(6);
    localparam logic [PC_W-1:0] PC_AD1  = PC_W'(7);
    localparam logic [PC_W-1:0] PC_AD2  = PC_W'(8);
    localparam logic [PC_W-1:0] PC_AD3  = PC_W'(9);
    localparam logic [PC_W-1:0] PC_AD4  = PC_W'(10);
    localparam logic [PC_W-1:0] PC_AD5  = PC_W'(11);
    localparam logic [PC_W-1:0] PC_BD0  = PC_W'(12);
    localparam logic [PC_W-1:0] PC_BD1  = PC_W'(13);
    localparam logic [PC_W-1:0] PC_BD2  = PC_W'(14);
    localparam logic [PC_W-1:0] PC_BD3  = PC_W'(15);
    localparam logic [PC_W-1:0] PC_BD4  = PC_W'(16);
    localparam logic [PC_W-1:0] PC_BD5  = PC_W'(17);
    localparam logic [PC_W-1:0] PC_SET0 = PC_W'(18);
    localparam logic [PC_W-1:0] PC_SET1 = PC_W'(19);
    localparam logic [PC_W-1:0] PC_SET2 = PC_W'(20);
    localparam logic [PC_W-1:0] PC_ENT0 = PC_W'(21);
    localparam logic [PC_W-1:0] PC_ENT1 = PC_W'(22);
    localparam logic [PC_W-1:0] PC_ENT2 = PC_W'(23);
    localparam logic [PC_W-1:0] PC_ENT3 = PC_W'(24);
    localparam logic [PC_W-1:0] PC_ENT4 = PC_W'(25);
    localparam logic [PC_W-1:0] PC_ENT5 = PC_W'(26);
    localparam logic [PC_W-1:0] PC_FIN  = PC_W'(27);

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = UW_NOP;
        case (pc)
            // start: squares, then d = 4b^2 - 4a^2*b + a^2
            PC_ST0: begin
                w.mul_en = 1'b1; w.opa = OP_A; w.opb = OP_A;
            end
            PC_ST1: begin
                w.wb = WB_SA; w.mul_en = 1'b1; w.opa = OP_B; w.opb = OP_B;
            end
            PC_ST2: begin
                w.wb = WB_SB; w.mul_en = 1'b1; w.opa = OP_SA; w.opb = OP_ONE;
            end
            PC_ST3: begin
                w.acc = ACC_LOAD; w.sh = 2'd0;
                w.mul_en = 1'b1; w.opa = OP_SB; w.opb = OP_ONE;
            end
            PC_ST4: begin
                w.acc = ACC_ADD; w.sh = 2'd2;
                w.mul_en = 1'b1; w.opa = OP_SA; w.opb = OP_B;
            end
            PC_ST5: begin
                w.acc = ACC_SUB; w.sh = 2'd2; w.cnd = CND_ALWAYS; w.target = PC_SET0;
            end
            // advance, region 1
            PC_AD0: begin
                w.mul_en = 1'b1; w.opa = OP_SB; w.opb = OP_X2P3;
                w.cnd = CND_R2; w.target = PC_BD0;
            end
            PC_AD1: begin
                w.cnd = CND_DNEG; w.target = PC_AD5;
            end
            PC_AD2: begin
                w.y_dec = 1'b1; w.acc = ACC_ADD; w.sh = 2'd2;
            end
            PC_AD3: begin
                w.mul_en = 1'b1; w.opa = OP_SA; w.opb = OP_Y;
            end
            PC_AD4: begin
                w.acc = ACC_SUB; w.sh = 2'd3; w.x_inc = 1'b1;
                w.cnd = CND_ALWAYS; w.target = PC_SET0;
            end
            PC_AD5: begin
                w.acc = ACC_ADD; w.sh = 2'd2; w.x_inc = 1'b1;
                w.cnd = CND_ALWAYS; w.target = PC_SET0;
            end
            // advance, region 2
            PC_BD0: begin
                w.mul_en = 1'b1; w.opa = OP_SA; w.opb = OP_Y2M3;
                w.cnd = CND_DNEG; w.target = PC_BD2;
            end
            PC_BD1: begin
                w.acc = ACC_SUB; w.sh = 2'd2; w.y_dec = 1'b1;
                w.cnd = CND_ALWAYS; w.target = PC_SET0;
            end
            PC_BD2: begin
                w.x_inc = 1'b1;
            end
            PC_BD3: begin
                w.mul_en = 1'b1; w.opa = OP_SB; w.opb = OP_X;
            end
            PC_BD4: begin
                w.acc = ACC_ADD; w.sh = 2'd3;
                w.mul_en = 1'b1; w.opa = OP_SA; w.opb = OP_Y2M3;
            end
            PC_BD5: begin
                w.acc = ACC_SUB; w.sh = 2'd2; w.y_dec = 1'b1;
                w.cnd = CND_ALWAYS; w.target = PC_SET0;
            end
            // region switch test
            PC_SET0: begin
                w.mul_en = 1'b1; w.opa = OP_SB; w.opb = OP_X;
                w.cnd = CND_R2; w.target = PC_FIN;
            end
            PC_SET1: begin
                w.q_load = 1'b1; w.mul_en = 1'b1; w.opa = OP_SA; w.opb = OP_Y;
            end
            PC_SET2: begin
                w.cnd = CND_LT; w.target = PC_FIN;
            end
            // region 2 entry: d = b^2(2x+1)^2 + 4a^2(y-1)^2 - 4a^2*b^2
            PC_ENT0: begin
                w.mul_en = 1'b1; w.opa = OP_TX; w.opb = OP_TX;
            end
            PC_ENT1: begin
                w.mul_en = 1'b1; w.opa = OP_SB; w.opb = OP_P;
            end
            PC_ENT2: begin
                w.acc = ACC_LOAD; w.sh = 2'd0;
                w.mul_en = 1'b1; w.opa = OP_YM; w.opb = OP_YM;
            end
            PC_ENT3: begin
                w.mul_en = 1'b1; w.opa = OP_SA; w.opb = OP_P;
            end
            PC_ENT4: begin
                w.acc = ACC_ADD; w.sh = 2'd2;
                w.mul_en = 1'b1; w.opa = OP_SA; w.opb = OP_SB;
            end
            PC_ENT5: begin
                w.acc = ACC_SUB; w.sh = 2'd2; w.set_r2 = 1'b1;
            end
            PC_FIN: begin
                w.fin = 1'b1; w.last = 1'b1;
            end
            default: begin
                w = UW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mer_dpath.sv @@
// Datapath of the ellipse rasterizer: operand muxes, multiplier, decision accumulator, walk.
`default_nettype none

module mer_dpath #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire mer_pkg::t_uword         i_ctl,
    input  wire                          i_start,
    input  wire                          i_adv,
    input  wire        [COORD_BITS-1:0]  i_center_x,
    input  wire        [COORD_BITS-1:0]  i_center_y,
    input  wire        [AXIS_BITS-1:0]   i_semi_x,
    input  wire        [AXIS_BITS-1:0]   i_semi_y,
    output mer_pkg::t_dstat              o_stat,
    output logic       [COORD_BITS-1:0]  o_cx,
    output logic       [COORD_BITS-1:0]  o_cy,
    output logic       [AXIS_BITS:0]     o_ox,
    output logic signed [AXIS_BITS+1:0]  o_oy
);

    localparam int SQ_W = 2 * AXIS_BITS;
    localparam int XW   = AXIS_BITS + 1;
    localparam int YW   = AXIS_BITS + 2;
    localparam int WM   = 2 * AXIS_BITS + 6;
    localparam int DW   = 2 * WM;

    logic        [AXIS_BITS-1:0]  r_a;
    logic        [AXIS_BITS-1:0]  r_b;
    logic        [SQ_W-1:0]       r_sa;
    logic        [SQ_W-1:0]       r_sb;
    logic        [COORD_BITS-1:0] r_cx;
    logic        [COORD_BITS-1:0] r_cy;
    logic        [XW-1:0]         r_x;
    logic signed [YW-1:0]         r_y;
    logic        [XW-1:0]         r_ox;
    logic signed [YW-1:0]         r_oy;
    logic signed [DW-1:0]         r_d;
    logic signed [DW-1:0]         r_p;
    logic signed [DW-1:0]         r_q;
    logic                         r_r2;
    logic                         r_active;
    logic                         r_done;

    logic signed [WM-1:0] w_sa, w_sb, w_a, w_b, w_tx, w_ym, w_p;
    logic signed [WM-1:0] w_x, w_y, w_x2p3, w_y2m3, w_one;
    logic signed [WM-1:0] op_a;
    logic signed [WM-1:0] op_b;
    logic signed [DW-1:0] mul_res;
    logic signed [DW-1:0] p_sh;
    logic signed [DW-1:0] n_d;
    logic                 fin_hit;

    assign w_sa   = WM'(r_sa);
    assign w_sb   = WM'(r_sb);
    assign w_a    = WM'(r_a);
    assign w_b    = WM'(r_b);
    assign w_x    = WM'(r_x);
    assign w_y    = WM'(r_y);
    assign w_tx   = (w_x <<< 1) + WM'(1);
    assign w_x2p3 = (w_x <<< 1) + WM'(3);
    assign w_y2m3 = (w_y <<< 1) - WM'(3);
    assign w_ym   = w_y - WM'(1);
    assign w_p    = r_p[WM-1:0];
    assign w_one  = WM'(1);

    always_comb begin
        case (i_ctl.opa)
            mer_pkg::OP_SA:   op_a = w_sa;
            mer_pkg::OP_SB:   op_a = w_sb;
            mer_pkg::OP_A:    op_a = w_a;
            mer_pkg::OP_B:    op_a = w_b;
            mer_pkg::OP_TX:   op_a = w_tx;
            mer_pkg::OP_YM:   op_a = w_ym;
            mer_pkg::OP_P:    op_a = w_p;
            mer_pkg::OP_X:    op_a = w_x;
            mer_pkg::OP_Y:    op_a = w_y;
            mer_pkg::OP_X2P3: op_a = w_x2p3;
            mer_pkg::OP_Y2M3: op_a = w_y2m3;
            default:          op_a = w_one;
        endcase
    end

    always_comb begin
        case (i_ctl.opb)
            mer_pkg::OP_SA:   op_b = w_sa;
            mer_pkg::OP_SB:   op_b = w_sb;
            mer_pkg::OP_A:    op_b = w_a;
            mer_pkg::OP_B:    op_b = w_b;
            mer_pkg::OP_TX:   op_b = w_tx;
            mer_pkg::OP_YM:   op_b = w_ym;
            mer_pkg::OP_P:    op_b = w_p;
            mer_pkg::OP_X:    op_b = w_x;
            mer_pkg::OP_Y:    op_b = w_y;
            mer_pkg::OP_X2P3: op_b = w_x2p3;
            mer_pkg::OP_Y2M3: op_b = w_y2m3;
            default:          op_b = w_one;
        endcase
    end

    assign mul_res = op_a * op_b;
    assign p_sh    = r_p <<< i_ctl.sh;

    always_comb begin
        case (i_ctl.acc)
            mer_pkg::ACC_LOAD: n_d = p_sh;
            mer_pkg::ACC_ADD:  n_d = r_d + p_sh;
            mer_pkg::ACC_SUB:  n_d = r_d - p_sh;
            default:           n_d = r_d;
        endcase
    end

    assign fin_hit = i_ctl.fin && r_r2 && r_y[YW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r2     <= 1'b0;
            r_active <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (i_start) begin
                r_r2     <= 1'b0;
                r_active <= 1'b1;
                r_done   <= 1'b0;
            end else if (i_adv) begin
                r_done <= 1'b0;
            end else begin
                if (i_ctl.set_r2) begin
                    r_r2 <= 1'b1;
                end
                if (fin_hit) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_semi_x;
            r_b  <= i_semi_y;
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_x  <= '0;
            r_y  <= YW'(i_semi_y);
        end else begin
            if (i_ctl.x_inc) begin
                r_x <= r_x + XW'(1);
            end
            if (i_ctl.y_dec) begin
                r_y <= r_y - YW'(1);
            end
        end
        if (i_adv) begin
            r_ox <= r_x;
            r_oy <= r_y;
        end
        if (i_ctl.mul_en) begin
            r_p <= mul_res;
        end
        if (i_ctl.q_load) begin
            r_q <= r_p;
        end
        r_d <= n_d;
        case (i_ctl.wb)
            mer_pkg::WB_SA: r_sa <= r_p[SQ_W-1:0];
            mer_pkg::WB_SB: r_sb <= r_p[SQ_W-1:0];
            default: ;
        endcase
    end

    assign o_stat.d_neg  = r_d[DW-1];
    assign o_stat.r2     = r_r2;
    assign o_stat.lt     = r_q < r_p;
    assign o_stat.active = r_active;
    assign o_stat.done   = r_done;
    assign o_cx          = r_cx;
    assign o_cy          = r_cy;
    assign o_ox          = r_ox;
    assign o_oy          = r_oy;

endmodule

`default_nettype wire

@@ rtl/core/midpoint_ellipse_rasterizer.sv @@
// Top level of the midpoint ellipse rasterizer: microcode sequencer and point output.
// Start request: the sequencer runs the start program, then the next request is taken; no results.
// Advance request on an active ellipse: the sequencer runs an advance program,
// then four points, one per cycle while the output is not stalled.
// Input stall is low only when idle; one request is in work at a time.
// Synchronous active-low reset: idle, no ellipse loaded, no output pending.
`default_nettype none

module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_kind,
    input  wire        [COORD_BITS-1:0]  i_center_x,
    input  wire        [COORD_BITS-1:0]  i_center_y,
    input  wire        [AXIS_BITS-1:0]   i_semi_x,
    input  wire        [AXIS_BITS-1:0]   i_semi_y,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic signed [COORD_BITS+1:0] o_point_x,
    output logic signed [COORD_BITS+1:0] o_point_y,
    output logic                         o_last_of_step,
    output logic                         o_ellipse_done
);

    localparam int PW = COORD_BITS + 2;

    mer_pkg::t_state             r_state, n_state;
    logic [mer_pkg::PC_W-1:0]    r_pc, n_pc;
    logic [1:0]                  r_cnt, n_cnt;
    logic                        r_adv, n_adv;

    mer_pkg::t_uword             uw;
    mer_pkg::t_uword             ctl;
    mer_pkg::t_dstat             stat;
    logic                        taken;
    logic                        in_acc;
    logic                        start;
    logic                        adv;

    logic [COORD_BITS-1:0]       dp_cx;
    logic [COORD_BITS-1:0]       dp_cy;
    logic [AXIS_BITS:0]          dp_ox;
    logic signed [AXIS_BITS+1:0] dp_oy;
    logic [PW-1:0]               cx_w, cy_w, ox_w, oy_w;

    assign uw     = mer_pkg::ucode(r_pc);
    assign in_acc = i_valid && !o_stall;
    assign start  = in_acc && (i_kind == mer_pkg::KIND_START);
    assign adv    = in_acc && (i_kind == mer_pkg::KIND_ADVANCE) && stat.active;

    always_comb begin
        case (uw.cnd)
            mer_pkg::CND_ALWAYS: taken = 1'b1;
            mer_pkg::CND_DNEG:   taken = stat.d_neg;
            mer_pkg::CND_R2:     taken = stat.r2;
            mer_pkg::CND_LT:     taken = stat.lt;
            default:             taken = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_cnt   = r_cnt;
        n_adv   = r_adv;
        case (r_state)
            mer_pkg::ST_IDLE: begin
                n_cnt = 2'd0;
                if (start) begin
                    n_state = mer_pkg::ST_RUN;
                    n_pc    = mer_pkg::PC_ST0;
                    n_adv   = 1'b0;
                end else if (adv) begin
                    n_state = mer_pkg::ST_RUN;
                    n_pc    = mer_pkg::PC_AD0;
                    n_adv   = 1'b1;
                end
            end
            mer_pkg::ST_RUN: begin
                if (taken) begin
                    n_pc = uw.target;
                end else if (uw.last) begin
                    n_state = r_adv ? mer_pkg::ST_EMIT : mer_pkg::ST_IDLE;
                end else begin
                    n_pc = r_pc + mer_pkg::PC_W'(1);
                end
            end
            mer_pkg::ST_EMIT: begin
                if (!i_stall) begin
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_state = mer_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = mer_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_stall        = (r_state != mer_pkg::ST_IDLE);
        o_valid        = (r_state == mer_pkg::ST_EMIT);
        o_last_of_step = (r_cnt == 2'd3);
        o_ellipse_done = stat.done;
        ctl            = (r_state == mer_pkg::ST_RUN) ? uw : mer_pkg::UW_NOP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mer_pkg::ST_IDLE;
            r_pc    <= '0;
            r_cnt   <= 2'd0;
            r_adv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
            r_adv   <= n_adv;
        end
    end

    mer_dpath #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_start    (start),
        .i_adv      (adv),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_semi_x   (i_semi_x),
        .i_semi_y   (i_semi_y),
        .o_stat     (stat),
        .o_cx       (dp_cx),
        .o_cy       (dp_cy),
        .o_ox       (dp_ox),
        .o_oy       (dp_oy)
    );

    // mirror order: (+x,+y) (+x,-y) (-x,-y) (-x,+y)
    assign cx_w = PW'(dp_cx);
    assign cy_w = PW'(dp_cy);
    assign ox_w = PW'(dp_ox);
    assign oy_w = PW'(dp_oy);

    assign o_point_x = r_cnt[1] ? (cx_w - ox_w) : (cx_w + ox_w);
    assign o_point_y = (r_cnt[1] ^ r_cnt[0]) ? (cy_w - oy_w) : (cy_w + oy_w);

endmodule

`default_nettype wire

@@ rtl/core/mer_chk.sv @@
// Port-level checker for the ellipse rasterizer, bound to the top level.
`default_nettype none

module mer_chk #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
) (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_valid,
    input wire                         o_stall,
    input wire                         i_kind,
    input wire [COORD_BITS-1:0]        i_center_x,
    input wire [COORD_BITS-1:0]        i_center_y,
    input wire [AXIS_BITS-1:0]         i_semi_x,
    input wire [AXIS_BITS-1:0]         i_semi_y,
    input wire                         o_valid,
    input wire                         i_stall,
    input wire signed [COORD_BITS+1:0] o_point_x,
    input wire signed [COORD_BITS+1:0] o_point_y,
    input wire                         o_last_of_step,
    input wire                         o_ellipse_done
);

    // a stalled request stays offered and unchanged
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_kind) && $stable(i_center_x)
            && $stable(i_center_y) && $stable(i_semi_x) && $stable(i_semi_y))
        else $error("stalled request changed");

    // no new request while points are pending
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while points pending");

    // a step gives four points back to back, then releases
    a_step_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_step && !i_stall |=> !o_valid)
        else $error("point after last of step");

    a_step_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_step && !i_stall |=> o_valid && $stable(o_ellipse_done))
        else $error("step cut short or done flag changed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_x) && $stable(o_point_y))
        else $error("stalled point changed");

endmodule

bind midpoint_ellipse_rasterizer mer_chk #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS)
) u_mer_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_kind         (i_kind),
    .i_center_x     (i_center_x),
    .i_center_y     (i_center_y),
    .i_semi_x       (i_semi_x),
    .i_semi_y       (i_semi_y),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_point_x      (o_point_x),
    .o_point_y      (o_point_y),
    .o_last_of_step (o_last_of_step),
    .o_ellipse_done (o_ellipse_done)
);

`default_nettype wire

@@ sim/testbench.sv @@
// Randomized testbench with a self-checking point predictor for the midpoint ellipse rasterizer.

module testbench;

    localparam int CB = mer_pkg::COORD_BITS_DEF;
    localparam int AB = mer_pkg::AXIS_BITS_DEF;
    localparam int PW = CB + 2;

    localparam logic KIND_START   = mer_pkg::KIND_START;
    localparam logic KIND_ADVANCE = mer_pkg::KIND_ADVANCE;

    localparam int RANDOM_ITEMS    = 306;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 40;

    typedef struct packed {
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        logic          last;
        logic          done;
    } t_point;

    class ellipse_checker;
        longint    walk_x, walk_y, ctr_x, ctr_y;
        bit [63:0] decision, sq_a, sq_b;
        bit        region_two, walking;
        t_point    due_points[$];
        int        mismatch_count;

        task report(input string what);
            $display("mismatch: %s", what);
            mismatch_count++;
        endtask

        function void add_point(longint px, longint py, bit last, bit done);
            t_point p;
            p.px   = PW'(px);
            p.py   = PW'(py);
            p.last = last;
            p.done = done;
            due_points.push_back(p);
        endfunction

        // region switch and end test, applied after start and after every step
        function bit settle();
            bit [63:0] tx;
            longint    ym;
            if (!region_two && !(sq_b * 64'(walk_x) < sq_a * 64'(walk_y))) begin
                tx = 64'(2 * walk_x + 1);
                ym = walk_y - 1;
                region_two = 1'b1;
                decision = sq_b * tx * tx + 64'd4 * sq_a * 64'(ym * ym)
                         - 64'd4 * sq_a * sq_b;
            end
            if (region_two && walk_y < 0) begin
                walking = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_request(logic kind, logic [CB-1:0] cx, logic [CB-1:0] cy,
                                   logic [AB-1:0] a, logic [AB-1:0] b);
            longint    x, y;
            bit [63:0] inc, ux, uy;
            bit        done;
            if (kind == KIND_START) begin
                ctr_x      = cx;
                ctr_y      = cy;
                sq_a       = 64'(a) * 64'(a);
                sq_b       = 64'(b) * 64'(b);
                walk_x     = 0;
                walk_y     = b;
                region_two = 1'b0;
                walking    = 1'b1;
                decision   = 64'd4 * sq_b - 64'd4 * sq_a * 64'(b) + sq_a;
                void'(settle());
            end else if (walking) begin
                x  = walk_x;
                y  = walk_y;
                ux = 64'(walk_x);
                uy = 64'(walk_y);
                if (!region_two) begin
                    inc = 64'd4 * sq_b * (64'd2 * ux + 64'd3);
                    if (decision[63]) begin
                        decision += inc;
                    end else begin
                        walk_y -= 1;
                        decision += inc - 64'd8 * sq_a * 64'(walk_y);
                    end
                    walk_x += 1;
                end else begin
                    if (decision[63]) begin
                        walk_x += 1;
                        decision += 64'd8 * sq_b * 64'(walk_x)
                                  - 64'd4 * sq_a * (64'd2 * uy - 64'd3);
                    end else begin
                        decision += 64'd4 * (64'd3 * sq_a - 64'd2 * sq_a * uy);
                    end
                    walk_y -= 1;
                end
                done = settle();
                add_point(ctr_x + x, ctr_y + y, 1'b0, done);
                add_point(ctr_x + x, ctr_y - y, 1'b0, done);
                add_point(ctr_x - x, ctr_y - y, 1'b0, done);
                add_point(ctr_x - x, ctr_y + y, 1'b1, done);
            end
        endfunction

        task check_point(logic [PW-1:0] px, logic [PW-1:0] py, logic last, logic done);
            t_point want;
            if (due_points.size() == 0) begin
                report($sformatf("point (%0d,%0d) with none due", $signed(px), $signed(py)));
                return;
            end
            want = due_points.pop_front();
            if (px !== want.px)
                report($sformatf("x %0d, want %0d", $signed(px), $signed(want.px)));
            if (py !== want.py)
                report($sformatf("y %0d, want %0d", $signed(py), $signed(want.py)));
            if (last !== want.last)
                report($sformatf("last_of_step %b, want %b", last, want.last));
            if (done !== want.done)
                report($sformatf("ellipse_done %b, want %b", done, want.done));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_kind;
    logic [CB-1:0]        i_center_x;
    logic [CB-1:0]        i_center_y;
    logic [AB-1:0]        i_semi_x;
    logic [AB-1:0]        i_semi_y;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [PW-1:0] o_point_x;
    logic signed [PW-1:0] o_point_y;
    logic                 o_last_of_step;
    logic                 o_ellipse_done;

    ellipse_checker board = new;
    int  sent_count     = 0;
    int  quiet_cycles   = 0;
    bit  steady_sender  = 1'b0;
    bit  hold_off_due   = 1'b0;
    bit  hold_off_done  = 1'b0;

    midpoint_ellipse_rasterizer uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic send_request(input logic kind, input logic [CB-1:0] cx,
                                input logic [CB-1:0] cy, input logic [AB-1:0] a,
                                input logic [AB-1:0] b);
        int gap, r;
        gap = 0;
        if (!steady_sender) begin
            r = $urandom_range(0, 99);
            if (r >= 90)
                gap = $urandom_range(8, 30);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_center_x <= cx;
        i_center_y <= cy;
        i_semi_x   <= a;
        i_semi_y   <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.take_request(kind, cx, cy, a, b);
        sent_count++;
    endtask

    // geometry fields are don't-care on an advance, so they get noise
    task automatic send_advance();
        send_request(KIND_ADVANCE, CB'($urandom), CB'($urandom), AB'($urandom),
                     AB'($urandom));
    endtask

    initial begin : stimulus
        int            base, steps, pick;
        logic [CB-1:0] cx, cy;
        logic [AB-1:0] a, b;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_kind     <= KIND_START;
        i_center_x <= '0;
        i_center_y <= '0;
        i_semi_x   <= '0;
        i_semi_y   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // advance with nothing loaded
        send_request(KIND_ADVANCE, '1, '1, '1, '1);
        send_request(KIND_START, '1, '1, '1, '1);
        repeat (3) send_advance();
        // unit circle at the origin, walked past its end
        send_request(KIND_START, '0, '0, AB'(1), AB'(1));
        repeat (4) send_advance();
        send_request(KIND_START, '0, '1, '1, AB'(1));
        repeat (2) send_advance();
        send_request(KIND_START, '1, '0, AB'(1), '1);
        repeat (2) send_advance();
        // zero semi-axes
        send_request(KIND_START, CB'(512), CB'(512), '0, AB'(2));
        repeat (4) send_advance();
        send_request(KIND_START, CB'(300), CB'(700), AB'(3), '0);
        repeat (2) send_advance();

        base = sent_count;
        while (sent_count - base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                send_advance();
            steady_sender = ($urandom_range(0, 3) == 0);
            cx   = CB'($urandom);
            cy   = CB'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                a = AB'($urandom_range(1, 511));
                b = AB'($urandom_range(1, 511));
                if ($urandom_range(0, 1) == 0)
                    a = AB'($urandom_range(256, 511));
                else
                    b = AB'($urandom_range(256, 511));
                steps = $urandom_range(10, 30);
            end else if (pick < 18) begin
                a = AB'($urandom_range(1, 60));
                b = AB'($urandom_range(1, 60));
                steps = a + b + 2 + $urandom_range(0, 2);
            end else begin
                a = AB'($urandom_range(0, 14));
                b = AB'($urandom_range(0, 14));
                if ($urandom_range(0, 6) == 0)
                    steps = $urandom_range(0, a + b);
                else
                    steps = a + b + 2 + $urandom_range(0, 2);
            end
            send_request(KIND_START, cx, cy, a, b);
            repeat (steps) begin
                if (sent_count - base < RANDOM_ITEMS)
                    send_advance();
            end
            if (sent_count - base > 120)
                hold_off_due = 1'b1;
        end
        i_valid <= 1'b0;

        while (board.due_points.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : receiver
        int n;
        forever begin
            if (hold_off_due && !hold_off_done) begin
                hold_off_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            i_stall <= 1'b0;
            repeat (n) @(posedge i_clk);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
            i_stall <= 1'b1;
            repeat (n) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_point(o_point_x, o_point_y, o_last_of_step, o_ellipse_done);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

@@ sim.f @@
rtl/core/mer_pkg.sv
rtl/core/mer_dpath.sv
rtl/core/midpoint_ellipse_rasterizer.sv
rtl/core/mer_chk.sv
sim/testbench.sv
